[rtl/two_key_record_sorter_macros.svh]
// Assertion macros shared by the sorter RTL
`ifndef TWO_KEY_RECORD_SORTER_MACROS_SVH
`define TWO_KEY_RECORD_SORTER_MACROS_SVH

// Check an expression on every clock edge outside reset
`define TKRS_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition leads to another in the next cycle
`define TKRS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/tkrs_pkg.sv]
// Types and constants of the two-key record sorter
package tkrs_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  typedef struct packed {
    logic [15:0] record_id;
    logic [15:0] brand_id;
    logic [15:0] color_id;
    logic [7:0]  gearbox_code;
    logic        vacant;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_record_id;
    logic [15:0] out_brand_id;
    logic [15:0] out_color_id;
    logic [7:0]  out_gearbox_code;
    logic        out_vacant;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic [15:0] record_id;
    logic [15:0] brand_id;
    logic [15:0] color_id;
    logic [7:0]  gearbox_code;
    logic        vacant;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

[rtl/two_key_record_sorter.sv]
// Two-key record sorter: loads a record set, exchange-sorts it in RAM, emits it in order
//
// Records are taken one per cycle while in_ready is high, up to MAX_RECORDS per set
// (further records are dropped, but their last_in still closes the set). A transaction
// with last_in set starts the sort: for a set of n records, an exchange sort on
// (gearbox_code, brand_id) runs through one key comparator and the single read port of
// the record RAM, one compare at a time in S_CMP, with S_LDI before and S_WRI after
// each outer pass. The set then leaves on the out_ channel one record at a time: each is
// read, loaded into the output register and held until out_ready takes it, the final
// one flagged by last_out. in_ready stays low from the closing transaction until the
// last output transaction completes.
`include "two_key_record_sorter_macros.svh"

module two_key_record_sorter import tkrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_LDI,
    S_CMP,
    S_WRI,
    S_EMRD,
    S_EMLD,
    S_EMHOLD
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] j_r;
  logic [IDX_W-1:0] k_r;
  rec_t             a_r;
  out_item_t        out_r;
  logic             out_valid_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata;
  rec_t             b_rec;
  logic             key_gt;
  logic             in_acc;
  logic             room;
  logic [CNT_W-1:0] count_nxt;
  rec_t             in_rec;

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign room      = (count_r < CNT_W'(MAX_RECORDS));
  assign count_nxt = room ? (count_r + CNT_W'(1)) : count_r;
  assign b_rec     = rec_t'(ram_rdata);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_rec.record_id    = in_data.record_id;
  assign in_rec.brand_id     = in_data.brand_id;
  assign in_rec.color_id     = in_data.color_id;
  assign in_rec.gearbox_code = in_data.gearbox_code;
  assign in_rec.vacant       = in_data.vacant;

  tkrs_cmp u_cmp (
    .a  (a_r),
    .b  (b_rec),
    .gt (key_gt)
  );

  tkrs_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[IDX_W-1:0];
    ram_wdata = in_rec;
    ram_raddr = '0;
    unique case (state_r)
      S_LOAD: begin
        ram_we = in_acc && room;
      end
      S_START: begin
        ram_raddr = '0;
      end
      S_LDI: begin
        ram_raddr = i_r + IDX_W'(1);
      end
      S_CMP: begin
        ram_we    = key_gt;
        ram_waddr = j_r;
        ram_wdata = a_r;
        ram_raddr = j_r + IDX_W'(1);
      end
      S_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = a_r;
        ram_raddr = i_r + IDX_W'(1);
      end
      S_EMRD: begin
        ram_raddr = k_r;
      end
      S_EMLD, S_EMHOLD: begin
        ram_raddr = k_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            count_r <= count_nxt;
            if (in_data.last_in) begin
              n_r <= count_nxt;
              i_r <= '0;
              k_r <= '0;
              state_r <= (count_nxt < CNT_W'(2)) ? S_EMRD : S_START;
            end
          end
        end
        S_START: begin
          state_r <= S_LDI;
        end
        S_LDI: begin
          a_r     <= b_rec;
          j_r     <= i_r + IDX_W'(1);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (key_gt) begin
            a_r <= b_rec;
          end
          if ((CNT_W'(j_r) + CNT_W'(1)) < n_r) begin
            j_r <= j_r + IDX_W'(1);
          end else begin
            state_r <= S_WRI;
          end
        end
        S_WRI: begin
          i_r <= i_r + IDX_W'(1);
          if ((CNT_W'(i_r) + CNT_W'(2)) < n_r) begin
            state_r <= S_LDI;
          end else begin
            k_r     <= '0;
            state_r <= S_EMRD;
          end
        end
        S_EMRD: begin
          state_r <= S_EMLD;
        end
        S_EMLD: begin
          out_r.out_record_id    <= b_rec.record_id;
          out_r.out_brand_id     <= b_rec.brand_id;
          out_r.out_color_id     <= b_rec.color_id;
          out_r.out_gearbox_code <= b_rec.gearbox_code;
          out_r.out_vacant       <= b_rec.vacant;
          out_r.last_out         <= ((CNT_W'(k_r) + CNT_W'(1)) == n_r);
          out_valid_r            <= 1'b1;
          state_r                <= S_EMHOLD;
        end
        S_EMHOLD: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_r.last_out) begin
              count_r <= '0;
              state_r <= S_LOAD;
            end else begin
              k_r     <= k_r + IDX_W'(1);
              state_r <= S_EMRD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  `TKRS_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while output pending")
  `TKRS_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_RECORDS), "record count past capacity")
  `TKRS_ASSERT(a_sort_waddr, (ram_we && state_r != S_LOAD) |-> (CNT_W'(ram_waddr) < n_r), "sort write past set end")
  `TKRS_ASSERT_NEXT(a_done_ready, out_valid && out_ready && out_data.last_out, in_ready && count_r == '0, "block not reloading after last output")

endmodule

[rtl/tkrs_ram.sv]
// Generic single-write, single-read RAM with registered read data
module tkrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/tkrs_cmp.sv]
// Key comparator: gearbox code first, then brand id, strictly greater
module tkrs_cmp import tkrs_pkg::*; (
  input  rec_t a,
  input  rec_t b,
  output logic gt
);

  always_comb begin
    if (a.gearbox_code != b.gearbox_code) begin
      gt = a.gearbox_code > b.gearbox_code;
    end else begin
      gt = a.brand_id > b.brand_id;
    end
  end

endmodule
